[rtl/augh_pkg.sv]
package augh_pkg;

	localparam int CELLS_PER_AXIS_DEF  = 8;
	localparam int MAX_ELEMENTS_DEF    = 64;
	localparam int COORD_FRAC_BITS_DEF = 16;

	localparam logic [1:0] KIND_INSERT = 2'd0;
	localparam logic [1:0] KIND_REMOVE = 2'd1;
	localparam logic [1:0] KIND_QUERY  = 2'd2;

	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_INS_IGN = 2'd1;
	localparam logic [1:0] STATUS_REM_IGN = 2'd2;

	localparam logic [2:0] REG_DOMAIN_MIN_X = 3'd0;
	localparam logic [2:0] REG_DOMAIN_MIN_Y = 3'd1;
	localparam logic [2:0] REG_DOMAIN_MIN_Z = 3'd2;
	localparam logic [2:0] REG_INV_CELL     = 3'd3;
	localparam logic [2:0] REG_GRID_EXTENT  = 3'd4;

	localparam logic [2:0] CONV_LAST = 3'd7;
	localparam logic [2:0] CONV_LAT  = 3'd2;

	typedef struct packed {
		logic [1:0]         kind;
		logic [5:0]         element_id;
		logic signed [31:0] box_min_x;
		logic signed [31:0] box_min_y;
		logic signed [31:0] box_min_z;
		logic signed [31:0] box_max_x;
		logic signed [31:0] box_max_y;
		logic signed [31:0] box_max_z;
	} in_t;

	typedef struct packed {
		logic [5:0] hit_id;
		logic       hit_valid;
		logic [1:0] status;
		logic       last;
	} out_t;

	typedef struct packed {
		logic signed [31:0] domain_min_x;
		logic signed [31:0] domain_min_y;
		logic signed [31:0] domain_min_z;
		logic [31:0]        inverse_cell_size;
		logic [3:0]         grid_extent;
	} cfg_t;

	typedef struct packed {
		logic       load;
		logic       conv_en;
		logic [2:0] conv_cnt;
		logic       walk_start;
		logic       walk_next;
		logic       box_wr;
		logic       box_rd;
		logic       box_load;
		logic       present_set;
		logic       present_clr;
		logic       bm_rd;
		logic       bm_wr;
		logic       union_clr;
		logic       union_or;
		logic       scan_start;
		logic       scan_next;
		logic       scan_take;
		logic       clr_wr;
		logic       out_load;
		logic       out_hit;
		logic [1:0] out_status;
	} cmd_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       id_ok;
		logic       id_present;
		logic       box_empty;
		logic       walk_last;
		logic       union_zero;
		logic       cur_bit;
		logic       last_hit;
		logic       clr_last;
		logic       slot_free;
	} sts_t;

endpackage

[rtl/augh_ram.sv]
module augh_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

[rtl/augh_ctrl.sv]
module augh_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  augh_pkg::sts_t sts,
	output augh_pkg::cmd_t cmd
);
	import augh_pkg::*;

	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_DISP  = 4'd2;
	localparam logic [3:0] S_CONV  = 4'd3;
	localparam logic [3:0] S_BOXRD = 4'd4;
	localparam logic [3:0] S_BOXLD = 4'd5;
	localparam logic [3:0] S_WINIT = 4'd6;
	localparam logic [3:0] S_WRD   = 4'd7;
	localparam logic [3:0] S_WWR   = 4'd8;
	localparam logic [3:0] S_WDONE = 4'd9;
	localparam logic [3:0] S_SCAN  = 4'd10;
	localparam logic [3:0] S_EMIT  = 4'd11;

	logic [3:0] state_q, state_d;
	logic [2:0] cnt_q, cnt_d;
	logic [1:0] status_q, status_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		status_d = status_q;
		cmd      = '0;
		cmd.conv_cnt   = cnt_q;
		cmd.out_status = status_q;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DISP;
				end
			end
			S_DISP: begin
				cnt_d = '0;
				case (sts.kind)
					KIND_INSERT: begin
						if (sts.id_ok && !sts.id_present) begin
							state_d = S_CONV;
						end else begin
							status_d = STATUS_INS_IGN;
							state_d  = S_EMIT;
						end
					end
					KIND_REMOVE: begin
						if (sts.id_ok && sts.id_present) begin
							state_d = S_BOXRD;
						end else begin
							status_d = STATUS_REM_IGN;
							state_d  = S_EMIT;
						end
					end
					KIND_QUERY: begin
						cmd.union_clr = 1'b1;
						state_d       = S_CONV;
					end
					default: begin
						status_d = STATUS_OK;
						state_d  = S_EMIT;
					end
				endcase
			end
			S_CONV: begin
				cmd.conv_en = 1'b1;
				cnt_d       = cnt_q + 3'd1;
				if (cnt_q == CONV_LAST) begin
					state_d = S_WINIT;
				end
			end
			S_BOXRD: begin
				cmd.box_rd = 1'b1;
				state_d    = S_BOXLD;
			end
			S_BOXLD: begin
				cmd.box_load = 1'b1;
				state_d      = S_WINIT;
			end
			S_WINIT: begin
				cmd.walk_start  = 1'b1;
				cmd.box_wr      = (sts.kind == KIND_INSERT);
				cmd.present_set = (sts.kind == KIND_INSERT);
				cmd.present_clr = (sts.kind == KIND_REMOVE);
				state_d = sts.box_empty ? S_WDONE : S_WRD;
			end
			S_WRD: begin
				cmd.bm_rd = 1'b1;
				state_d   = S_WWR;
			end
			S_WWR: begin
				cmd.union_or = (sts.kind == KIND_QUERY);
				cmd.bm_wr    = (sts.kind != KIND_QUERY);
				if (sts.walk_last) begin
					state_d = S_WDONE;
				end else begin
					cmd.walk_next = 1'b1;
					state_d       = S_WRD;
				end
			end
			S_WDONE: begin
				if (sts.kind == KIND_QUERY && !sts.union_zero) begin
					cmd.scan_start = 1'b1;
					state_d        = S_SCAN;
				end else begin
					status_d = STATUS_OK;
					state_d  = S_EMIT;
				end
			end
			S_SCAN: begin
				if (!sts.cur_bit) begin
					cmd.scan_next = 1'b1;
				end else if (sts.slot_free) begin
					cmd.out_load  = 1'b1;
					cmd.out_hit   = 1'b1;
					cmd.scan_take = 1'b1;
					cmd.scan_next = 1'b1;
					if (sts.last_hit) begin
						state_d = S_IDLE;
					end
				end
			end
			S_EMIT: begin
				if (sts.slot_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			cnt_q    <= '0;
			status_q <= STATUS_OK;
		end else begin
			state_q  <= state_d;
			cnt_q    <= cnt_d;
			status_q <= status_d;
		end
	end
endmodule

[rtl/augh_dp.sv]
module augh_dp #(
	parameter int CELLS_PER_AXIS  = 8,
	parameter int MAX_ELEMENTS    = 64,
	parameter int COORD_FRAC_BITS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  augh_pkg::cfg_t cfg,
	input  augh_pkg::in_t  in_data,
	input  augh_pkg::cmd_t cmd,
	output augh_pkg::sts_t sts,
	output logic           out_valid,
	input  logic           out_ready,
	output augh_pkg::out_t out_data
);
	import augh_pkg::*;

	localparam int CW  = (CELLS_PER_AXIS > 1) ? $clog2(CELLS_PER_AXIS) : 1;
	localparam int NC  = CELLS_PER_AXIS * CELLS_PER_AXIS * CELLS_PER_AXIS;
	localparam int AW  = $clog2(NC);
	localparam int EW  = $clog2(MAX_ELEMENTS);
	localparam int PW  = 64 - 2 * COORD_FRAC_BITS;
	localparam logic [AW-1:0] STRIDE_X  = AW'(CELLS_PER_AXIS * CELLS_PER_AXIS);
	localparam logic [AW-1:0] STRIDE_Y  = AW'(CELLS_PER_AXIS);
	localparam logic [AW-1:0] CLR_LAST  = AW'(NC - 1);
	localparam logic [4:0]    CELLS_MAX = 5'(CELLS_PER_AXIS);

	in_t in_q;
	logic [MAX_ELEMENTS-1:0] present_q, union_q, bit_mask;
	logic [EW-1:0] id_ix, scan_q;
	logic [CW-1:0] box_q [6];
	logic [CW-1:0] x_q, y_q, z_q;
	logic [AW-1:0] clr_q, walk_addr;
	logic [31:0] d_s1;
	logic pos_s1;
	logic [63:0] prod_s2;
	logic signed [31:0] coord, origin;
	logic signed [32:0] diff;
	logic [4:0] ext, top;
	logic [PW-1:0] shifted;
	logic [CW-1:0] cell_ix;
	logic [2:0] sidx;
	logic [6*CW-1:0] box_wdata, box_rdata;
	logic [MAX_ELEMENTS-1:0] bm_rdata, bm_wdata;
	logic [MAX_ELEMENTS-1:0] scan_rest;
	logic out_valid_q;
	out_t out_q;

	assign id_ix    = in_q.element_id[EW-1:0];
	assign bit_mask = MAX_ELEMENTS'(1) << id_ix;

	always_comb begin
		ext = {1'b0, cfg.grid_extent};
		if (ext == 5'd0) begin
			ext = 5'd1;
		end
		if (ext > CELLS_MAX) begin
			ext = CELLS_MAX;
		end
		top = ext - 5'd1;
	end

	always_comb begin
		case (cmd.conv_cnt)
			3'd0: coord = in_q.box_min_x;
			3'd1: coord = in_q.box_min_y;
			3'd2: coord = in_q.box_min_z;
			3'd3: coord = in_q.box_max_x;
			3'd4: coord = in_q.box_max_y;
			default: coord = in_q.box_max_z;
		endcase
		case (cmd.conv_cnt) inside
			3'd0, 3'd3: origin = cfg.domain_min_x;
			3'd1, 3'd4: origin = cfg.domain_min_y;
			default: origin = cfg.domain_min_z;
		endcase
	end

	assign diff    = {coord[31], coord} - {origin[31], origin};
	assign shifted = prod_s2[63:2*COORD_FRAC_BITS];
	assign cell_ix = (shifted > PW'(top)) ? CW'(top) : shifted[CW-1:0];
	assign sidx    = cmd.conv_cnt - CONV_LAT;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			in_q <= in_data;
		end
		if (cmd.conv_en) begin
			d_s1    <= diff[31:0];
			pos_s1  <= !diff[32] && (diff != '0);
			prod_s2 <= pos_s1 ? ({32'b0, d_s1} * {32'b0, cfg.inverse_cell_size}) : '0;
			if (cmd.conv_cnt >= CONV_LAT) begin
				box_q[sidx] <= cell_ix;
			end
		end
		if (cmd.box_load) begin
			for (int k = 0; k < 6; k++) begin
				box_q[k] <= box_rdata[k*CW +: CW];
			end
		end
		if (cmd.walk_start) begin
			x_q <= box_q[0];
			y_q <= box_q[1];
			z_q <= box_q[2];
		end else if (cmd.walk_next) begin
			if (z_q != box_q[5]) begin
				z_q <= z_q + CW'(1);
			end else begin
				z_q <= box_q[2];
				if (y_q != box_q[4]) begin
					y_q <= y_q + CW'(1);
				end else begin
					y_q <= box_q[1];
					x_q <= x_q + CW'(1);
				end
			end
		end
		if (cmd.scan_start) begin
			scan_q <= '0;
		end else if (cmd.scan_next) begin
			scan_q <= scan_q + EW'(1);
		end
		if (cmd.out_load) begin
			if (cmd.out_hit) begin
				out_q.hit_id    <= 6'(scan_q);
				out_q.hit_valid <= 1'b1;
				out_q.status    <= STATUS_OK;
				out_q.last      <= (scan_rest == '0);
			end else begin
				out_q.hit_id    <= '0;
				out_q.hit_valid <= 1'b0;
				out_q.status    <= cmd.out_status;
				out_q.last      <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q   <= '0;
			union_q     <= '0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.present_set) begin
				present_q <= present_q | bit_mask;
			end else if (cmd.present_clr) begin
				present_q <= present_q & ~bit_mask;
			end
			if (cmd.union_clr) begin
				union_q <= '0;
			end else if (cmd.union_or) begin
				union_q <= union_q | bm_rdata;
			end else if (cmd.scan_take) begin
				union_q <= scan_rest;
			end
			if (cmd.clr_wr) begin
				clr_q <= clr_q + AW'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign scan_rest = union_q & ~(MAX_ELEMENTS'(1) << scan_q);
	assign walk_addr = AW'(x_q) * STRIDE_X + AW'(y_q) * STRIDE_Y + AW'(z_q);
	assign box_wdata = {box_q[5], box_q[4], box_q[3], box_q[2], box_q[1], box_q[0]};
	assign bm_wdata  = cmd.clr_wr ? '0 :
		(in_q.kind == KIND_INSERT) ? (bm_rdata | bit_mask) : (bm_rdata & ~bit_mask);

	augh_ram #(
		.WIDTH(6 * CW),
		.DEPTH(MAX_ELEMENTS)
	) u_box_ram (
		.clk  (clk),
		.we   (cmd.box_wr),
		.waddr(id_ix),
		.wdata(box_wdata),
		.re   (cmd.box_rd),
		.raddr(id_ix),
		.rdata(box_rdata)
	);

	augh_ram #(
		.WIDTH(MAX_ELEMENTS),
		.DEPTH(NC)
	) u_bitmap_ram (
		.clk  (clk),
		.we   (cmd.clr_wr || cmd.bm_wr),
		.waddr(cmd.clr_wr ? clr_q : walk_addr),
		.wdata(bm_wdata),
		.re   (cmd.bm_rd),
		.raddr(walk_addr),
		.rdata(bm_rdata)
	);

	always_comb begin
		sts.kind       = in_q.kind;
		sts.id_ok      = (7'(in_q.element_id) < 7'(MAX_ELEMENTS));
		sts.id_present = present_q[id_ix];
		sts.box_empty  = (box_q[0] > box_q[3]) || (box_q[1] > box_q[4]) ||
			(box_q[2] > box_q[5]);
		sts.walk_last  = (x_q == box_q[3]) && (y_q == box_q[4]) && (z_q == box_q[5]);
		sts.union_zero = (union_q == '0);
		sts.cur_bit    = union_q[scan_q];
		sts.last_hit   = (scan_rest == '0);
		sts.clr_last   = (clr_q == CLR_LAST);
		sts.slot_free  = !out_valid_q || out_ready;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;
endmodule

[rtl/aabb_uniform_grid_hash.sv]
// Uniform 3D grid broad-phase index. After reset the block clears all CELLS_PER_AXIS^3
// cells of the cell bitmap memory before in_ready first rises; configuration writes
// are taken during that pass. Items are handled one at a time. An ignored insert or
// remove, or an unused kind, emits only its status item, without touching the grid.
// An insert, or a query, first converts the six corner coordinates through one shared
// 32x32 multiplier, two stages deep, and then does a read-modify-write or a read of the
// simple dual-port bitmap memory for every covered cell. A remove reads its stored box
// back and does the same walk. A query with hits then scans the ids up to and including
// its highest hit, emitting one item per hit; each result that waits on out_ready adds
// its stall. A single output register lets the last result wait for out_ready while
// the next item is accepted.
module aabb_uniform_grid_hash #(
	parameter int CELLS_PER_AXIS  = augh_pkg::CELLS_PER_AXIS_DEF,
	parameter int MAX_ELEMENTS    = augh_pkg::MAX_ELEMENTS_DEF,
	parameter int COORD_FRAC_BITS = augh_pkg::COORD_FRAC_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  augh_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output augh_pkg::out_t out_data,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [4:0]     paddr,
	input  logic [31:0]    pwdata,
	output logic [31:0]    prdata,
	output logic           pready
);
	import augh_pkg::*;

	cfg_t cfg_q;
	cmd_t cmd;
	sts_t sts;
	logic [2:0] reg_ix;

	assign pready = 1'b1;
	assign reg_ix = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.domain_min_x      <= '0;
			cfg_q.domain_min_y      <= '0;
			cfg_q.domain_min_z      <= '0;
			cfg_q.inverse_cell_size <= 32'd65536;
			cfg_q.grid_extent       <= 4'd8;
		end else if (psel && penable && pwrite) begin
			unique case (reg_ix)
				REG_DOMAIN_MIN_X: cfg_q.domain_min_x      <= pwdata;
				REG_DOMAIN_MIN_Y: cfg_q.domain_min_y      <= pwdata;
				REG_DOMAIN_MIN_Z: cfg_q.domain_min_z      <= pwdata;
				REG_INV_CELL:     cfg_q.inverse_cell_size <= pwdata;
				REG_GRID_EXTENT:  cfg_q.grid_extent       <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_ix)
			REG_DOMAIN_MIN_X: prdata = cfg_q.domain_min_x;
			REG_DOMAIN_MIN_Y: prdata = cfg_q.domain_min_y;
			REG_DOMAIN_MIN_Z: prdata = cfg_q.domain_min_z;
			REG_INV_CELL:     prdata = cfg_q.inverse_cell_size;
			REG_GRID_EXTENT:  prdata = {28'b0, cfg_q.grid_extent};
			default:          prdata = '0;
		endcase
	end

	augh_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	augh_dp #(
		.CELLS_PER_AXIS (CELLS_PER_AXIS),
		.MAX_ELEMENTS   (MAX_ELEMENTS),
		.COORD_FRAC_BITS(COORD_FRAC_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_data  (in_data),
		.cmd      (cmd),
		.sts      (sts),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item accepted while previous item still in work");

	a_only_hits_continue: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.last |-> out_data.hit_valid)
		else $error("non-final item without a hit");

	a_miss_is_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.hit_valid |-> out_data.last && (out_data.hit_id == '0))
		else $error("miss item not final or with nonzero id");

	a_hit_status_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.hit_valid |-> out_data.status == STATUS_OK)
		else $error("hit item with nonzero status");
endmodule

[sim/aabb_uniform_grid_hash_tb.sv]
`timescale 1ns / 100ps

module aabb_uniform_grid_hash_tb;
	import augh_pkg::*;

	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int         N_AXIS      = CELLS_PER_AXIS_DEF;
	localparam int         N_ELEM      = MAX_ELEMENTS_DEF;
	localparam int         FRAC2       = 2 * COORD_FRAC_BITS_DEF;
	localparam int         U           = 1 << COORD_FRAC_BITS_DEF;

	typedef struct {
		in_t  item;
		bit   typed;
		out_t want;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	in_t         in_data;
	logic        out_valid;
	logic        out_ready;
	out_t        out_data;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	aabb_uniform_grid_hash u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// grid shadow
	logic [63:0]        cell_bitmap [N_AXIS*N_AXIS*N_AXIS];
	logic [3:0]         elem_box_lo [N_ELEM][3];
	logic [3:0]         elem_box_hi [N_ELEM][3];
	logic [63:0]        elem_present;
	logic signed [31:0] grid_origin [3];
	logic [31:0]        grid_inv;
	logic [3:0]         grid_ext;

	out_t     pending_hits [$];
	dir_row_t dir_rows [$];
	bit       row_typed;
	out_t     row_want;
	bit       quiet;
	bit       rx_hold;
	int       n_mismatch;
	int       n_results;
	int       n_hits;
	int       n_items;
	int       n_kind [4];

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	function automatic logic [3:0] coord_to_cell(logic signed [31:0] c, int axis);
		longint              d;
		longint unsigned     prod;
		longint unsigned     cell_ix;
		int                  top;
		top = (grid_ext == 0) ? 0 : ((grid_ext > N_AXIS) ? N_AXIS - 1 : grid_ext - 1);
		d = longint'(c) - longint'(grid_origin[axis]);
		if (d <= 0)
			return 4'd0;
		prod = longint'(d) * longint'({32'd0, grid_inv});
		cell_ix = prod >> FRAC2;
		if (cell_ix > top)
			cell_ix = top;
		return cell_ix[3:0];
	endfunction

	function automatic void grid_apply(in_t it);
		logic [3:0]  lo [3];
		logic [3:0]  hi [3];
		logic [63:0] acc;
		logic [63:0] bit_m;
		out_t        r;
		int          id;
		id = it.element_id;
		bit_m = 64'd1 << id;
		r = '{hit_id: 6'd0, hit_valid: 1'b0, status: STATUS_OK, last: 1'b1};
		n_kind[it.kind]++;
		if (it.kind == KIND_INSERT || it.kind == KIND_QUERY) begin
			lo[0] = coord_to_cell(it.box_min_x, 0);
			lo[1] = coord_to_cell(it.box_min_y, 1);
			lo[2] = coord_to_cell(it.box_min_z, 2);
			hi[0] = coord_to_cell(it.box_max_x, 0);
			hi[1] = coord_to_cell(it.box_max_y, 1);
			hi[2] = coord_to_cell(it.box_max_z, 2);
		end else if (it.kind == KIND_REMOVE) begin
			lo = elem_box_lo[id];
			hi = elem_box_hi[id];
		end
		acc = '0;
		case (it.kind)
			KIND_INSERT: begin
				if (elem_present[id]) begin
					r.status = STATUS_INS_IGN;
				end else begin
					elem_box_lo[id] = lo;
					elem_box_hi[id] = hi;
					elem_present[id] = 1'b1;
				end
			end
			KIND_REMOVE: begin
				if (!elem_present[id])
					r.status = STATUS_REM_IGN;
				else
					elem_present[id] = 1'b0;
			end
			default: ;
		endcase
		if (it.kind != KIND_UNUSED && r.status == STATUS_OK) begin
			for (int x = lo[0]; x <= hi[0]; x++)
				for (int y = lo[1]; y <= hi[1]; y++)
					for (int z = lo[2]; z <= hi[2]; z++) begin
						if (it.kind == KIND_INSERT)
							cell_bitmap[(x*N_AXIS+y)*N_AXIS+z] |= bit_m;
						else if (it.kind == KIND_REMOVE)
							cell_bitmap[(x*N_AXIS+y)*N_AXIS+z] &= ~bit_m;
						else
							acc |= cell_bitmap[(x*N_AXIS+y)*N_AXIS+z];
					end
		end
		if (it.kind == KIND_QUERY && acc != 0) begin
			for (int i = 0; i < 64; i++)
				if (acc[i]) begin
					r.hit_id = i[5:0];
					r.hit_valid = 1'b1;
					r.last = ((acc >> i) == 64'd1);
					pending_hits = {pending_hits, r};
				end
		end else begin
			pending_hits = {pending_hits, (row_typed ? row_want : r)};
		end
	endfunction

	always @(posedge clk)
		if (in_valid && in_ready) begin
			n_items++;
			grid_apply(in_data);
		end

	always @(posedge clk)
		if (out_valid && out_ready) begin
			n_results++;
			if (out_data.hit_valid)
				n_hits++;
			if (pending_hits.size() == 0) begin
				n_mismatch++;
				if (n_mismatch <= 10)
					$display("unexpected result %p", out_data);
			end else begin
				out_t want;
				want = pending_hits.pop_front();
				if (out_data !== want) begin
					n_mismatch++;
					if (n_mismatch <= 10)
						$display("mismatch: expected %p got %p", want, out_data);
				end
			end
		end

	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rx_hold) begin
				out_ready <= 1'b0;
				repeat (300) @(posedge clk);
				rx_hold = 0;
				out_ready <= 1'b1;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic send(in_t it);
		in_data <= it;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic reg_write(logic [2:0] idx, logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_DOMAIN_MIN_X: grid_origin[0] = val;
			REG_DOMAIN_MIN_Y: grid_origin[1] = val;
			REG_DOMAIN_MIN_Z: grid_origin[2] = val;
			REG_INV_CELL:     grid_inv = val;
			REG_GRID_EXTENT:  grid_ext = val[3:0];
			default: ;
		endcase
	endtask

	task automatic drain_and_config(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
			logic [31:0] inv, logic [3:0] ext);
		in_valid <= 1'b0;
		@(posedge clk);
		wait (pending_hits.size() == 0);
		repeat (30) @(posedge clk);
		reg_write(REG_DOMAIN_MIN_X, ox);
		reg_write(REG_DOMAIN_MIN_Y, oy);
		reg_write(REG_DOMAIN_MIN_Z, oz);
		reg_write(REG_INV_CELL, inv);
		reg_write(REG_GRID_EXTENT, {28'd0, ext});
	endtask

	function automatic in_t mk(logic [1:0] k, int id, int x0, int y0, int z0,
			int x1, int y1, int z1);
		in_t it;
		it.kind = k;
		it.element_id = id[5:0];
		it.box_min_x = x0;
		it.box_min_y = y0;
		it.box_min_z = z0;
		it.box_max_x = x1;
		it.box_max_y = y1;
		it.box_max_z = z1;
		return it;
	endfunction

	function automatic void add_row(in_t it, bit typed, logic [1:0] st);
		dir_row_t r;
		r.item = it;
		r.typed = typed;
		r.want = '{hit_id: 6'd0, hit_valid: 1'b0, status: st, last: 1'b1};
		dir_rows = {dir_rows, r};
	endfunction

	function automatic logic [31:0] coord_for_cell(int axis, int t);
		longint          c;
		longint unsigned num;
		if (grid_inv == 0 || $urandom_range(0, 9) == 0)
			return $urandom;
		if (t == 0 && $urandom_range(0, 2) == 0)
			c = longint'(grid_origin[axis]) - $urandom_range(0, 1 << 20);
		else begin
			num = (longint'(t) << FRAC2) + $urandom;
			c = longint'(grid_origin[axis]) + num / grid_inv;
		end
		if (c > 64'sd2147483647)
			c = 64'sd2147483647;
		if (c < -64'sd2147483648)
			c = -64'sd2147483648;
		return c[31:0];
	endfunction

	function automatic in_t rand_item();
		in_t it;
		int  sel;
		int  t;
		int  w;
		sel = $urandom_range(0, 99);
		it.kind = (sel < 40) ? KIND_INSERT : (sel < 65) ? KIND_REMOVE :
			(sel < 95) ? KIND_QUERY : KIND_UNUSED;
		it.element_id = $urandom_range(0, 63);
		if (it.kind == KIND_REMOVE && elem_present != 0 && $urandom_range(0, 3) != 0)
			while (!elem_present[it.element_id])
				it.element_id = $urandom_range(0, 63);
		t = $urandom_range(0, 8); w = $urandom_range(0, 2);
		it.box_min_x = coord_for_cell(0, t);
		it.box_max_x = coord_for_cell(0, ($urandom_range(0, 11) == 0) ? t - 1 : t + w);
		t = $urandom_range(0, 8); w = $urandom_range(0, 2);
		it.box_min_y = coord_for_cell(1, t);
		it.box_max_y = coord_for_cell(1, t + w);
		t = $urandom_range(0, 8); w = $urandom_range(0, 2);
		it.box_min_z = coord_for_cell(2, t);
		it.box_max_z = coord_for_cell(2, t + w);
		return it;
	endfunction

	task automatic random_items(int n);
		for (int i = 0; i < n; i++)
			send(rand_item());
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		quiet = 0;
		rx_hold = 0;
		row_typed = 0;
		row_want = '0;
		n_mismatch = 0;
		n_results = 0;
		n_hits = 0;
		n_items = 0;
		foreach (n_kind[i]) n_kind[i] = 0;
		foreach (cell_bitmap[i]) cell_bitmap[i] = '0;
		elem_present = '0;
		grid_origin[0] = 0; grid_origin[1] = 0; grid_origin[2] = 0;
		grid_inv = 32'd65536;
		grid_ext = 4'd8;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		add_row(mk(KIND_QUERY, 0, 32'h80000000, 32'h80000000, 32'h80000000,
			32'h7fffffff, 32'h7fffffff, 32'h7fffffff), 1, STATUS_OK);
		add_row(mk(KIND_INSERT, 0, 0, 0, 0, U, U, U), 1, STATUS_OK);
		add_row(mk(KIND_INSERT, 0, 0, 0, 0, U, U, U), 1, STATUS_INS_IGN);
		add_row(mk(KIND_REMOVE, 5, 0, 0, 0, 0, 0, 0), 1, STATUS_REM_IGN);
		add_row(mk(KIND_UNUSED, 63, -1, -1, -1, -1, -1, -1), 1, STATUS_OK);
		add_row(mk(KIND_INSERT, 63, 32'h80000000, 32'h80000000, 32'h80000000,
			32'h7fffffff, 32'h7fffffff, 32'h7fffffff), 1, STATUS_OK);
		add_row(mk(KIND_INSERT, 17, 5*U, 0, 0, 2*U, 3*U, 3*U), 1, STATUS_OK);
		add_row(mk(KIND_INSERT, 42, 7*U, 7*U, 7*U, 7*U+1, 7*U, 32'h7fffffff), 0, STATUS_OK);
		add_row(mk(KIND_INSERT, 9, 3*U-1, 3*U, 3*U+U/2, 4*U, 4*U-1, 3*U), 0, STATUS_OK);
		add_row(mk(KIND_QUERY, 0, 32'h80000000, 32'h80000000, 32'h80000000,
			32'h7fffffff, 32'h7fffffff, 32'h7fffffff), 0, STATUS_OK);
		add_row(mk(KIND_QUERY, 0, 3*U, 3*U, 3*U, 3*U, 3*U, 3*U), 0, STATUS_OK);
		add_row(mk(KIND_QUERY, 0, 7*U, 7*U, 7*U, 9*U, 9*U, 9*U), 0, STATUS_OK);
		add_row(mk(KIND_QUERY, 0, 4*U, 0, 0, U, 7*U, 7*U), 0, STATUS_OK);
		add_row(mk(KIND_REMOVE, 63, 0, 0, 0, 0, 0, 0), 1, STATUS_OK);
		add_row(mk(KIND_REMOVE, 17, 0, 0, 0, 0, 0, 0), 1, STATUS_OK);
		add_row(mk(KIND_REMOVE, 17, 0, 0, 0, 0, 0, 0), 1, STATUS_REM_IGN);
		add_row(mk(KIND_QUERY, 0, 0, 0, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff),
			0, STATUS_OK);
		add_row(mk(KIND_REMOVE, 42, 0, 0, 0, 0, 0, 0), 0, STATUS_OK);
		add_row(mk(KIND_QUERY, 0, -U, -U, -U, 8*U, 8*U, 8*U), 0, STATUS_OK);
		foreach (dir_rows[i]) begin
			row_typed <= dir_rows[i].typed;
			row_want <= dir_rows[i].want;
			send(dir_rows[i].item);
		end
		row_typed <= 0;

		drain_and_config(32'h80000000, 32'h7fffffff, $urandom, 32'hffffffff, 4'd1);
		random_items(70);
		drain_and_config($urandom, $urandom, $urandom, 32'h4000, 4'd15);
		random_items(20);
		rx_hold = 1;
		random_items(60);
		drain_and_config(-5*U, -5*U, -5*U, 2*U, 4'd5);
		random_items(40);
		in_valid <= 1'b0;
		@(posedge clk);
		wait (pending_hits.size() == 0);
		@(posedge clk);
		random_items(40);
		drain_and_config(0, 0, 0, 32'd0, 4'd0);
		random_items(40);
		drain_and_config(0, 0, 0, 32'd1, 4'd8);
		random_items(30);
		drain_and_config(0, 0, 0, 32'd65536, 4'd8);
		random_items(80);
		quiet = 1;
		random_items(50);
		in_valid <= 1'b0;
		@(posedge clk);

		wait (pending_hits.size() == 0);
		repeat (50) @(posedge clk);
		$display("%0d items (insert %0d, remove %0d, query %0d, unused %0d), %0d results",
			n_items, n_kind[0], n_kind[1], n_kind[2], n_kind[3], n_results);
		$display("%0d hits across six grid settings, %0d mismatches", n_hits, n_mismatch);
		if (n_mismatch == 0 && pending_hits.size() == 0)
			$display("** aabb_uniform_grid_hash: PASSED **");
		else
			$display("** aabb_uniform_grid_hash: FAILED **");
		$finish;
	end

	initial begin
		#60000000;
		$display("timeout with %0d results outstanding", pending_hits.size());
		$display("** aabb_uniform_grid_hash: FAILED **");
		$finish;
	end

endmodule
